// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk with rst as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// When ante holds, cons must hold in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dfhe_pkg.sv =====
// ----------------------------------------------------------------------------
// dfhe_pkg
// Types and constants of the DEFLATE fixed-Huffman token encoder.
// ----------------------------------------------------------------------------
package dfhe_pkg;

  // Largest backward distance that the encoder codes
  localparam int MAX_DISTANCE = 32768;

  // Token kinds
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_HEADER  = 2'd0;
  localparam mode_t MODE_LITERAL = 2'd1;
  localparam mode_t MODE_MATCH   = 2'd2;
  localparam mode_t MODE_END     = 2'd3;

  // Packed token: longest match is 8 + 5 + 5 + 13 = 31 bits
  localparam int TOK_BITS_W = 31;
  localparam int TOK_CNT_W  = 5;

  // Bit accumulator: up to 7 pending bits plus one packed token
  localparam int ACC_W     = 38;
  localparam int ACC_CNT_W = 6;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [TOK_BITS_W-1:0] bits;   // stream bits, first bit in the LSB
    logic [TOK_CNT_W-1:0]  nbits;  // number of valid bits
    logic                  eob;    // end of block: flush partial byte
  } tok_t;

endpackage

// ===== hw/rtl/dfhe_if.sv =====
// ----------------------------------------------------------------------------
// dfhe_if
// Valid/ready channels: token input and stream byte output.
// ----------------------------------------------------------------------------
interface dfhe_token_if;
  import dfhe_pkg::*;

  logic        valid;
  logic        ready;
  mode_t       mode;
  logic [7:0]  literal_byte;
  logic [8:0]  match_length;
  logic [15:0] match_distance;

  modport source (output valid, output mode, output literal_byte,
                  output match_length, output match_distance, input ready);
  modport sink   (input valid, input mode, input literal_byte,
                  input match_length, input match_distance, output ready);
endinterface

interface dfhe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== hw/rtl/dfhe_front.sv =====
// ----------------------------------------------------------------------------
// dfhe_front
// Accepts tokens, maps them to fixed-Huffman codes and extra bits, and packs
// each token into one LSB-first bit word with its length.
// ----------------------------------------------------------------------------
module dfhe_front (
  input  logic              clk,
  input  logic              rst,
  dfhe_token_if.sink        token,
  output logic              tok_valid,
  input  logic              tok_ready,
  output dfhe_pkg::tok_t    tok
);
  import dfhe_pkg::*;

  // Classified token, stage 1
  typedef struct packed {
    logic [8:0]  sym_bits;  // reversed Huffman code
    logic [3:0]  sym_n;
    logic [4:0]  len_x;     // length extra bits
    logic [2:0]  len_xn;
    logic [4:0]  dst_code;  // reversed 5-bit distance code
    logic [12:0] dst_x;     // distance extra bits
    logic [3:0]  dst_xn;
    logic        is_match;
    logic        eob;
  } class_t;

  localparam logic [16:0] MaxDist     = 17'(MAX_DISTANCE);
  localparam logic [8:0]  Lit8Last    = 9'd143;
  localparam logic [8:0]  Len7Last    = 9'd279;
  localparam logic [8:0]  LenSymBase  = 9'd257;
  localparam logic [8:0]  Code8Base   = 9'h030;
  localparam logic [8:0]  Code9Base   = 9'h190;
  localparam logic [8:0]  Code8HiBase = 9'h0C0;
  localparam logic [8:0]  Code9First  = 9'd144;
  localparam logic [8:0]  Code8HiFirst = 9'd280;

  function automatic logic [8:0] rev9(input logic [8:0] v);
    logic [8:0] r;
    for (int i = 0; i < 9; i++) r[i] = v[8-i];
    return r;
  endfunction

  function automatic logic [4:0] rev5(input logic [4:0] v);
    logic [4:0] r;
    for (int i = 0; i < 5; i++) r[i] = v[4-i];
    return r;
  endfunction

  logic [8:0]  len_c;
  logic [15:0] dst_c;
  logic [7:0]  len_o;
  logic [14:0] dst_o;
  logic [2:0]  len_p;
  logic [3:0]  dst_p;
  logic [1:0]  len_top;
  logic [4:0]  len_slot;
  logic [4:0]  dst_slot;
  logic [8:0]  len_sym;
  logic [8:0]  lit_sym;
  logic [7:0]  code8;
  logic [8:0]  code9;
  class_t      cls;

  logic        s1_valid;
  class_t      s1;
  logic        s2_valid;
  tok_t        s2;
  tok_t        tok_word;
  logic [4:0]  off1;
  logic [4:0]  off2;
  logic        s1_open;
  logic        s2_open;

  // Classify the incoming token
  always_comb begin
    cls      = '0;
    len_top  = '0;
    len_slot = '0;
    dst_slot = '0;
    code8    = '0;
    code9    = '0;

    // clamp length and distance into the coded range
    len_c = token.match_length;
    if (token.match_length < 9'd3) len_c = 9'd3;
    else if (token.match_length > 9'd258) len_c = 9'd258;
    dst_c = token.match_distance;
    if (token.match_distance == '0) dst_c = 16'd1;
    else if ({1'b0, token.match_distance} > MaxDist) dst_c = MaxDist[15:0];
    len_o = 8'(len_c - 9'd3);
    dst_o = 15'(dst_c - 16'd1);

    // leading one positions
    len_p = '0;
    for (int i = 0; i < 8; i++) if (len_o[i]) len_p = 3'(i);
    dst_p = '0;
    for (int i = 0; i < 15; i++) if (dst_o[i]) dst_p = 4'(i);

    // length slot and extra bits
    if (len_o == 8'd255) begin
      len_slot = 5'd28;
    end else if (len_o < 8'd8) begin
      len_slot = 5'(len_o);
    end else begin
      len_top    = 2'(len_o >> (len_p - 3'd2));
      len_slot   = {len_p - 3'd1, len_top};
      cls.len_xn = len_p - 3'd2;
      cls.len_x  = 5'(len_o & ((8'd1 << cls.len_xn) - 8'd1));
    end
    len_sym = LenSymBase + 9'(len_slot);

    // distance slot and extra bits
    if (dst_o < 15'd4) begin
      dst_slot = 5'(dst_o);
    end else begin
      dst_slot   = {dst_p, dst_o[4'(dst_p - 4'd1)]};
      cls.dst_xn = dst_p - 4'd1;
      cls.dst_x  = 13'(dst_o & ((15'd1 << cls.dst_xn) - 15'd1));
    end
    cls.dst_code = rev5(dst_slot);

    lit_sym = {1'b0, token.literal_byte};

    case (token.mode)
      MODE_HEADER: begin
        // BFINAL=1, BTYPE=01
        cls.sym_bits = 9'd3;
        cls.sym_n    = 4'd3;
      end
      MODE_LITERAL: begin
        if (lit_sym <= Lit8Last) begin
          code8        = 8'(Code8Base + lit_sym);
          cls.sym_bits = rev9({code8, 1'b0});
          cls.sym_n    = 4'd8;
        end else begin
          code9        = Code9Base + lit_sym - Code9First;
          cls.sym_bits = rev9(code9);
          cls.sym_n    = 4'd9;
        end
      end
      MODE_MATCH: begin
        cls.is_match = 1'b1;
        if (len_sym <= Len7Last) begin
          cls.sym_bits = rev9({7'(len_slot + 5'd1), 2'b00});
          cls.sym_n    = 4'd7;
        end else begin
          code8        = 8'(Code8HiBase + len_sym - Code8HiFirst);
          cls.sym_bits = rev9({code8, 1'b0});
          cls.sym_n    = 4'd8;
        end
      end
      default: begin
        // end of block: code 256 is seven zero bits
        cls.sym_bits = '0;
        cls.sym_n    = 4'd7;
        cls.eob      = 1'b1;
      end
    endcase
  end

  // Pack the classified fields into one bit word
  always_comb begin
    off1 = 5'(s1.sym_n) + 5'(s1.len_xn);
    off2 = off1 + 5'd5;
    tok_word.eob = s1.eob;
    if (s1.is_match) begin
      tok_word.bits  = TOK_BITS_W'(s1.sym_bits)
                     | (TOK_BITS_W'(s1.len_x) << s1.sym_n)
                     | (TOK_BITS_W'(s1.dst_code) << off1)
                     | (TOK_BITS_W'(s1.dst_x) << off2);
      tok_word.nbits = off2 + 5'(s1.dst_xn);
    end else begin
      tok_word.bits  = TOK_BITS_W'(s1.sym_bits);
      tok_word.nbits = 5'(s1.sym_n);
    end
  end

  // Two-stage pipeline handshake
  assign s2_open     = !s2_valid || tok_ready;
  assign s1_open     = !s1_valid || s2_open;
  assign token.ready = s1_open;
  assign tok_valid   = s2_valid;
  assign tok         = s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_open) s1_valid <= token.valid;
      if (s2_open) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_open && token.valid) s1 <= cls;
    if (s2_open && s1_valid) s2 <= tok_word;
  end

endmodule

// ===== hw/rtl/dfhe_queue.sv =====
// ----------------------------------------------------------------------------
// dfhe_queue
// Short FIFO of packed tokens between the front and the back.
// ----------------------------------------------------------------------------
module dfhe_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  dfhe_pkg::tok_t wr_tok,
  output logic           rd_valid,
  input  logic           rd_ready,
  output dfhe_pkg::tok_t rd_tok
);
  import dfhe_pkg::*;
  `include "assert_macros.svh"

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PtrW:0]   Full    = (PtrW+1)'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  tok_t            slots [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;
  logic            push;
  logic            pop;

  assign wr_ready = (count != Full);
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_tok   = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_tok;
  end

  `ASSERT_ALWAYS(a_count_bound, count <= Full, "queue fill level beyond depth")
  `ASSERT_NEXT(a_push_fills, push && !pop, count != '0, "transfer in left queue empty")
  `ASSERT_NEXT(a_full_holds, (count == Full) && !pop, count == Full,
               "full queue lost an entry without a transfer out")

endmodule

// ===== hw/rtl/dfhe_back.sv =====
// ----------------------------------------------------------------------------
// dfhe_back
// Merges packed tokens into the bit accumulator and sends one completed
// byte per cycle through an output register while stream.ready allows;
// flushes at end of block.
module dfhe_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  dfhe_pkg::tok_t q_tok,
  dfhe_byte_if.source    stream
);
  import dfhe_pkg::*;
  `include "assert_macros.svh"

  localparam logic [ACC_CNT_W-1:0] ByteBits = ACC_CNT_W'(8);
  localparam logic [ACC_CNT_W-1:0] AccMax   = ACC_CNT_W'(ACC_W);

  logic [ACC_W-1:0]     acc, acc_e, acc_next;
  logic [ACC_CNT_W-1:0] cnt, cnt_e, cnt_next;
  logic                 flush, flush_e, flush_next;
  logic                 have_byte;
  logic                 out_free;
  logic                 emit;
  logic                 emit_last;
  logic                 pop;
  logic                 out_valid;
  logic [7:0]           out_byte;
  logic                 out_last;

  // Byte emission, then merge of the next token into what is left
  always_comb begin
    have_byte = (cnt >= ByteBits) || (flush && (cnt != '0));
    out_free  = !out_valid || stream.ready;
    emit      = have_byte && out_free;

    acc_e   = acc;
    cnt_e   = cnt;
    flush_e = flush;
    if (emit) begin
      if (cnt >= ByteBits) begin
        acc_e = acc >> 8;
        cnt_e = cnt - ByteBits;
      end else begin
        acc_e   = '0;
        cnt_e   = '0;
        flush_e = 1'b0;
      end
    end

    // token done once under a byte remains and no flush is owed
    emit_last = (cnt_e < ByteBits) && !(flush_e && (cnt_e != '0));
    q_ready   = emit_last;
    pop       = emit_last && q_valid;

    acc_next   = acc_e;
    cnt_next   = cnt_e;
    flush_next = flush_e && (cnt_e != '0);
    if (pop) begin
      acc_next   = acc_e | (ACC_W'(q_tok.bits) << cnt_e[2:0]);
      cnt_next   = cnt_e + ACC_CNT_W'(q_tok.nbits);
      flush_next = q_tok.eob;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      cnt       <= '0;
      flush     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      acc   <= acc_next;
      cnt   <= cnt_next;
      flush <= flush_next;
      if (out_free) out_valid <= emit;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= acc[7:0];
      out_last <= emit_last;
    end
  end

  assign stream.valid       = out_valid;
  assign stream.out_byte    = out_byte;
  assign stream.last_of_run = out_last;

  `ASSERT_ALWAYS(a_cnt_bound, cnt <= AccMax, "accumulator holds too many bits")
  `ASSERT_ALWAYS(a_flush_nonempty, !flush || (cnt != '0), "flush owed on empty accumulator")
  `ASSERT_NEXT(a_stall_holds, have_byte && !out_free, $stable(cnt) && $stable(acc),
               "accumulator changed while output stalled")

endmodule

// ===== hw/rtl/deflate_fixed_huffman_token_encoder.sv =====
// ----------------------------------------------------------------------------
// deflate_fixed_huffman_token_encoder
// DEFLATE fixed-Huffman token encoder: tokens in, compressed bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   token  : one DEFLATE token per transfer (mode 0 header, 1 literal,
//            2 length/distance match, 3 end of block with flush).
//   stream : compressed bytes, first bit in the LSB; last_of_run marks the
//            final byte that a token produces. A token may produce none.
// Path: the first byte of a token passes the two front stages, the queue, the
//   accumulator and the output register in that order.
// Throughput: the back end sends one byte per cycle while stream.ready is high
//   and takes the next token in the cycle the current one's last byte leaves.
//   A token yields up to one byte for a header, up to two for a literal, up
//   to four for a match and up to two for end of block. Tokens are taken back
//   to back while the queue has room.
// Reset: clears the pipeline, queue and accumulator; the stream starts empty.
// Stall: when stream.ready is low the byte holds in the output register, the
//   accumulator holds while a byte waits, and the front keeps taking tokens
//   until its two stages and the two-entry queue fill, then token.ready drops.
// ----------------------------------------------------------------------------
module deflate_fixed_huffman_token_encoder (
  input  logic         clk,
  input  logic         rst,
  dfhe_token_if.sink   token,
  dfhe_byte_if.source  stream
);
  import dfhe_pkg::*;

  logic tf_valid;
  logic tf_ready;
  tok_t tf_tok;
  logic tb_valid;
  logic tb_ready;
  tok_t tb_tok;

  dfhe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .token     (token),
    .tok_valid (tf_valid),
    .tok_ready (tf_ready),
    .tok       (tf_tok)
  );

  dfhe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (tf_valid),
    .wr_ready (tf_ready),
    .wr_tok   (tf_tok),
    .rd_valid (tb_valid),
    .rd_ready (tb_ready),
    .rd_tok   (tb_tok)
  );

  dfhe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (tb_valid),
    .q_ready (tb_ready),
    .q_tok   (tb_tok),
    .stream  (stream)
  );

endmodule
